FILE: rtl/core/ohist_pkg.sv
// ----------------------------------------------------------------------------
// ohist_pkg
// Shared types and constants of the opcode histogram table: transaction
// payloads, mode codes and the control group handed from cell to cell.
// ----------------------------------------------------------------------------
package ohist_pkg;

  localparam int unsigned OPCODE_W = 12;
  localparam int unsigned COUNT_W  = 48;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned USED_W   = 9;

  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  read_index;
  } ohist_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  entry_index;
    logic [OPCODE_W-1:0] opcode_out;
    logic [COUNT_W-1:0]  count_out;
    logic                new_entry;
    logic                dropped;
    logic                entry_valid;
    logic [USED_W-1:0]   entries_used;
  } ohist_out_t;

  // control group of a transaction traveling down the chain
  typedef struct packed {
    logic valid;
    logic mode;
    logic hit;
    logic fresh;
  } ohist_ctl_t;

endpackage

FILE: rtl/core/opcode_histogram_table.sv
// ----------------------------------------------------------------------------
// opcode_histogram_table
// Associative histogram of executed opcodes built as a chain of entry cells.
// ----------------------------------------------------------------------------
// The table is a row of ENTRIES cells, one per entry; every transaction walks
// the row one cell per cycle while the row advances, each cell registering it,
// and a new transaction enters every cycle unless the row is stalled. Cells
// are visited in order, so each transaction sees exactly the updates of those
// ahead of it. A stall on the result channel freezes the whole row and holds
// off the input side. Read transactions report an entry only once every
// earlier transaction has passed it.
module opcode_histogram_table #(
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned OPCODE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ohist_pkg::ohist_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ohist_pkg::ohist_out_t out_data
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  ohist_pkg::ohist_ctl_t         ctl_s  [0:ENTRIES];
  logic [OPCODE_BITS-1:0]        op_s   [0:ENTRIES];
  logic [ohist_pkg::INDEX_W-1:0] ridx_s [0:ENTRIES];
  logic [IDX_W-1:0]              idx_s  [0:ENTRIES];
  logic [COUNT_BITS-1:0]         cnt_s  [0:ENTRIES];
  logic [CNT_W-1:0]              used_s [0:ENTRIES];
  logic [ENTRIES-1:0]            occ_v;

  logic                          advance;
  logic [15:0]                   op_wide;

  ohist_pkg::ohist_ctl_t         last_ctl;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // high opcode bits beyond OPCODE_BITS are ignored
  assign op_wide = 16'(in_data.opcode);

  assign ctl_s[0]  = '{valid: in_valid, mode: in_data.mode, hit: 1'b0, fresh: 1'b0};
  assign op_s[0]   = op_wide[OPCODE_BITS-1:0];
  assign ridx_s[0] = in_data.read_index;
  assign idx_s[0]  = '0;
  assign cnt_s[0]  = '0;
  assign used_s[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ohist_cell #(
      .ENTRY       (g),
      .OPCODE_BITS (OPCODE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .ctl_i   (ctl_s[g]),
      .op_i    (op_s[g]),
      .ridx_i  (ridx_s[g]),
      .idx_i   (idx_s[g]),
      .cnt_i   (cnt_s[g]),
      .used_i  (used_s[g]),
      .ctl_o   (ctl_s[g+1]),
      .op_o    (op_s[g+1]),
      .ridx_o  (ridx_s[g+1]),
      .idx_o   (idx_s[g+1]),
      .cnt_o   (cnt_s[g+1]),
      .used_o  (used_s[g+1]),
      .occ_o   (occ_v[g])
    );
  end

  assign last_ctl  = ctl_s[ENTRIES];
  assign out_valid = last_ctl.valid;

  always_comb begin
    out_data              = '0;
    out_data.entries_used = ohist_pkg::USED_W'(used_s[ENTRIES]);
    if (last_ctl.mode == ohist_pkg::MODE_READ) begin
      out_data.entry_index = ridx_s[ENTRIES];
      if (last_ctl.hit) begin
        out_data.opcode_out  = ohist_pkg::OPCODE_W'(op_s[ENTRIES]);
        out_data.count_out   = ohist_pkg::COUNT_W'(cnt_s[ENTRIES]);
        out_data.entry_valid = 1'b1;
      end
    end else if (last_ctl.hit) begin
      out_data.entry_index = ohist_pkg::INDEX_W'(idx_s[ENTRIES]);
      out_data.opcode_out  = ohist_pkg::OPCODE_W'(op_s[ENTRIES]);
      out_data.count_out   = ohist_pkg::COUNT_W'(cnt_s[ENTRIES]);
      out_data.new_entry   = last_ctl.fresh;
      out_data.entry_valid = 1'b1;
    end else begin
      out_data.dropped = 1'b1;
    end
  end

`ifndef SYNTHESIS
  // entries in use always form a contiguous block from entry zero
  assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_v + 1'b1) & occ_v) == '0)
    else $error("entry occupancy is not contiguous");

  // a miss is dropped only when every entry is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> used_s[ENTRIES] == CNT_W'(ENTRIES))
    else $error("miss dropped while table not full");

  // a freshly allocated entry is valid and starts at one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_entry |->
      out_data.entry_valid && !out_data.dropped && out_data.count_out == 1)
    else $error("bad fresh entry result");

  // occupancy of entry zero never drops once set
  assert property (@(posedge clk) disable iff (!rst_n)
    occ_v[0] |=> occ_v[0])
    else $error("entry zero lost its occupancy");
`endif

endmodule

FILE: rtl/core/ohist_cell.sv
// ----------------------------------------------------------------------------
// ohist_cell
// One table entry of the histogram chain. Holds a tag, a count and an
// in-use flag, serves the transaction passing through and hands it on.
// ----------------------------------------------------------------------------
module ohist_cell #(
  parameter int unsigned ENTRY       = 0,
  parameter int unsigned OPCODE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 48,
  parameter int unsigned IDX_W       = 8,
  parameter int unsigned CNT_W       = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  ohist_pkg::ohist_ctl_t         ctl_i,
  input  logic [OPCODE_BITS-1:0]        op_i,
  input  logic [ohist_pkg::INDEX_W-1:0] ridx_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic [COUNT_BITS-1:0]         cnt_i,
  input  logic [CNT_W-1:0]              used_i,
  output ohist_pkg::ohist_ctl_t         ctl_o,
  output logic [OPCODE_BITS-1:0]        op_o,
  output logic [ohist_pkg::INDEX_W-1:0] ridx_o,
  output logic [IDX_W-1:0]              idx_o,
  output logic [COUNT_BITS-1:0]         cnt_o,
  output logic [CNT_W-1:0]              used_o,
  output logic                          occ_o
);

  logic [OPCODE_BITS-1:0]        tag_r, tag_nxt;
  logic [COUNT_BITS-1:0]         store_r, store_nxt;
  logic                          occ_r, occ_nxt;
  ohist_pkg::ohist_ctl_t         ctl_r, ctl_nxt;
  logic [OPCODE_BITS-1:0]        op_r, op_nxt;
  logic [ohist_pkg::INDEX_W-1:0] ridx_r;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              used_r, used_nxt;

  logic                          match;
  logic                          ridx_hit;
  logic [COUNT_BITS-1:0]         store_inc;

  assign match     = occ_r && (tag_r == op_i);
  assign ridx_hit  = (32'(ridx_i) == 32'(ENTRY));
  // saturating increment
  assign store_inc = (store_r == {COUNT_BITS{1'b1}}) ? store_r : store_r + 1'b1;

  always_comb begin
    ctl_nxt   = ctl_i;
    op_nxt    = op_i;
    idx_nxt   = idx_i;
    cnt_nxt   = cnt_i;
    tag_nxt   = tag_r;
    store_nxt = store_r;
    occ_nxt   = occ_r;
    if (ctl_i.valid) begin
      if (ctl_i.mode == ohist_pkg::MODE_COUNT) begin
        if (!ctl_i.hit) begin
          if (match) begin
            ctl_nxt.hit = 1'b1;
            idx_nxt     = IDX_W'(ENTRY);
            cnt_nxt     = store_inc;
            store_nxt   = store_inc;
          end else if (!occ_r) begin
            // first free entry: nothing earlier matched, so allocate here
            ctl_nxt.hit   = 1'b1;
            ctl_nxt.fresh = 1'b1;
            idx_nxt       = IDX_W'(ENTRY);
            cnt_nxt       = COUNT_BITS'(1);
            tag_nxt       = op_i;
            store_nxt     = COUNT_BITS'(1);
            occ_nxt       = 1'b1;
          end
        end
      end else if (occ_r && ridx_hit) begin
        ctl_nxt.hit = 1'b1;
        idx_nxt     = IDX_W'(ENTRY);
        op_nxt      = tag_r;
        cnt_nxt     = store_r;
      end
    end
    used_nxt = used_i + CNT_W'(occ_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      ctl_r <= '0;
    end else if (advance) begin
      occ_r <= occ_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_r      <= tag_nxt;
      store_r    <= store_nxt;
      op_r       <= op_nxt;
      ridx_r     <= ridx_i;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
      used_r     <= used_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign op_o   = op_r;
  assign ridx_o = ridx_r;
  assign idx_o  = idx_r;
  assign cnt_o  = cnt_r;
  assign used_o = used_r;
  assign occ_o  = occ_r;

endmodule

FILE: verif/opcode_histogram_checker.sv
// ----------------------------------------------------------------------------
// opcode_histogram_checker
// Watches both channels of the opcode histogram table, keeps its own copy of
// the tag and count store, predicts the report of every accepted transaction
// and compares each returned transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module opcode_histogram_checker #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  ohist_pkg::ohist_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  ohist_pkg::ohist_out_t out_data,
  output int unsigned           fail_cnt,
  output int unsigned           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ohist_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  logic [ohist_pkg::OPCODE_W-1:0] tag_mem   [ENTRIES];
  logic [ohist_pkg::COUNT_W-1:0]  count_mem [ENTRIES];
  int unsigned                    used_cnt;
  ohist_pkg::ohist_out_t          entry_reports_q[$];

  function automatic ohist_pkg::ohist_out_t histogram_update(input ohist_pkg::ohist_in_t item);
    ohist_pkg::ohist_out_t rep;
    int                    hit_idx;
    rep = '0;
    hit_idx = -1;
    if (item.mode == ohist_pkg::MODE_READ) begin
      rep.entry_index = item.read_index;
      if (item.read_index < used_cnt) begin
        rep.opcode_out  = tag_mem[item.read_index];
        rep.count_out   = count_mem[item.read_index];
        rep.entry_valid = 1'b1;
      end
    end else begin
      // tags are distinct, lowest index wins anyway
      for (int i = 0; i < used_cnt; i++) begin
        if (hit_idx < 0 && tag_mem[i] == item.opcode) hit_idx = i;
      end
      if (hit_idx >= 0) begin
        if (count_mem[hit_idx] != COUNT_MAX) count_mem[hit_idx] = count_mem[hit_idx] + 1'b1;
        rep.entry_index = ohist_pkg::INDEX_W'(hit_idx);
        rep.opcode_out  = item.opcode;
        rep.count_out   = count_mem[hit_idx];
        rep.entry_valid = 1'b1;
      end else if (used_cnt >= ENTRIES) begin
        // table full: miss is dropped, nothing stored
        rep.dropped = 1'b1;
      end else begin
        tag_mem[used_cnt]   = item.opcode;
        count_mem[used_cnt] = ohist_pkg::COUNT_W'(1);
        rep.entry_index     = ohist_pkg::INDEX_W'(used_cnt);
        rep.opcode_out      = item.opcode;
        rep.count_out       = ohist_pkg::COUNT_W'(1);
        rep.new_entry       = 1'b1;
        rep.entry_valid     = 1'b1;
        used_cnt++;
      end
    end
    rep.entries_used = ohist_pkg::USED_W'(used_cnt);
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ohist_pkg::ohist_out_t want;
    if (!rst_n) begin
      used_cnt = 0;
      entry_reports_q.delete();
    end else begin
      // retire before predicting, a result never belongs to this cycle's input
      if (out_valid && !out_stall) begin
        if (entry_reports_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected transaction, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = entry_reports_q.pop_front();
          check_field("entry_index", 64'(want.entry_index),
                      64'(out_data.entry_index));
          check_field("opcode_out", 64'(want.opcode_out),
                      64'(out_data.opcode_out));
          check_field("count_out", 64'(want.count_out),
                      64'(out_data.count_out));
          check_field("new_entry", 64'(want.new_entry),
                      64'(out_data.new_entry));
          check_field("dropped", 64'(want.dropped),
                      64'(out_data.dropped));
          check_field("entry_valid", 64'(want.entry_valid),
                      64'(out_data.entry_valid));
          check_field("entries_used", 64'(want.entries_used),
                      64'(out_data.entries_used));
        end
      end
      if (in_valid && !in_stall) entry_reports_q.push_back(histogram_update(in_data));
    end
    pending <= entry_reports_q.size();
  end

endmodule

FILE: verif/opcode_histogram_table_test.sv
// ----------------------------------------------------------------------------
// opcode_histogram_table_test
// Drives count and read transactions into the opcode histogram table in bursts,
// with a stalling receiver, fills the table past capacity, and reports the
// verdict from the failure count and the pending count of the checker.
// ----------------------------------------------------------------------------
module opcode_histogram_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES        = 256;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned DRAIN_AT       = 300;
  localparam int unsigned HOLDOFF_AT     = 600;
  localparam int unsigned HOLDOFF_CYCLES = 1000;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  ohist_pkg::ohist_in_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ohist_pkg::ohist_out_t out_data;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned holdoff_left;
  bit          held_off;

  // opcodes in the order they took entries, used to aim for hits
  logic [ohist_pkg::OPCODE_W-1:0] known_ops[$];
  bit                             seen_op [1 << ohist_pkg::OPCODE_W];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  opcode_histogram_table #(
    .ENTRIES (ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  opcode_histogram_checker #(
    .ENTRIES (ENTRIES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_cnt  (fail_cnt),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("opcode_histogram_table_test failed");
      $finish;
    end
  end

  // receiver: one long hold-off so the row fills, otherwise a pattern per window
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (!held_off && items_sent >= HOLDOFF_AT) begin
      held_off <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (cycles[11:10])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= (cycles[2:0] < 3'd3);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  task automatic send_item(input ohist_pkg::ohist_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (item.mode == ohist_pkg::MODE_COUNT && !seen_op[item.opcode] &&
        known_ops.size() < ENTRIES) begin
      seen_op[item.opcode] = 1'b1;
      known_ops.push_back(item.opcode);
    end
  endtask

  task automatic count_op(input logic [ohist_pkg::OPCODE_W-1:0] op);
    ohist_pkg::ohist_in_t item;
    item.mode = ohist_pkg::MODE_COUNT;
    item.opcode = op;
    item.read_index = ohist_pkg::INDEX_W'($urandom);
    send_item(item);
  endtask

  task automatic read_at(input logic [ohist_pkg::INDEX_W-1:0] idx);
    ohist_pkg::ohist_in_t item;
    item.mode = ohist_pkg::MODE_READ;
    item.opcode = ohist_pkg::OPCODE_W'($urandom);
    item.read_index = idx;
    send_item(item);
  endtask

  // valid must already be scheduled low by the caller
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic ohist_pkg::ohist_in_t random_item();
    ohist_pkg::ohist_in_t item;
    int unsigned          pick;
    item.mode = ohist_pkg::MODE_COUNT;
    item.opcode = ohist_pkg::OPCODE_W'($urandom);
    item.read_index = ohist_pkg::INDEX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      item.mode = ohist_pkg::MODE_READ;
      // half the reads take an index from zero up to the count of known opcodes
      if (pick < 10) item.read_index = ohist_pkg::INDEX_W'($urandom_range(0, known_ops.size()));
    end else if (pick < 65 && known_ops.size() != 0) begin
      item.opcode = known_ops[$urandom_range(0, known_ops.size() - 1)];
    end
    return item;
  endfunction

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned burst;
    int unsigned gap;
    bit          drained;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, extreme opcodes, hits, boundary reads
    read_at(8'd0);
    read_at(8'd255);
    count_op(12'h000);
    count_op(12'hFFF);
    count_op(12'h000);
    count_op(12'hFFF);
    count_op(12'hAAA);
    count_op(12'h555);
    read_at(8'd0);
    read_at(8'd1);
    read_at(8'd3);
    read_at(8'd4);
    read_at(8'd255);
    count_op(12'h555);
    count_op(12'h800);
    count_op(12'h001);
    read_at(8'd5);
    read_at(8'd6);
    count_op(12'h000);
    in_valid <= 1'b0;
    wait_drained();

    // random misses fill the table; later misses are dropped
    n = 0;
    drained = 1'b0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
        send_item(random_item());
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (!drained && n >= DRAIN_AT) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        wait_drained();
      end else if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (ENTRIES + 16) @(posedge clk);

    if (fail_cnt == 0 && pending == 0) begin
      $display("opcode_histogram_table_test passed");
    end else begin
      $display("opcode_histogram_table_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ohist_pkg.sv
rtl/core/ohist_cell.sv
rtl/core/opcode_histogram_table.sv
verif/opcode_histogram_checker.sv
verif/opcode_histogram_table_test.sv
